>>> hdl/sdet_pkg.sv
package sdet_pkg;

   localparam int unsigned POSITION_BITS_DEFAULT = 32;
   localparam int unsigned OUT_POSITION_BITS     = 32;
   localparam int unsigned NAME_LENGTH_TARGET    = 6;
   localparam int unsigned MAX_PASSES            = 8;

   localparam logic [7:0] CHAR_LT    = 8'h3C;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_BANG  = 8'h21;
   localparam logic [7:0] CHAR_DASH  = 8'h2D;
   localparam logic [7:0] CHAR_GT    = 8'h3E;
   localparam logic [7:0] CASE_BIT   = 8'h20;

   typedef enum logic [4:0] {
      M_PLAIN          = 5'd0,
      M_LT             = 5'd1,
      M_ESC_START      = 5'd2,
      M_ESC_START_DASH = 5'd3,
      M_END_NAME       = 5'd4,
      M_ESC            = 5'd5,
      M_ESC_DASH       = 5'd6,
      M_ESC_DASH_DASH  = 5'd7,
      M_ESC_LT         = 5'd8,
      M_ESC_END_NAME   = 5'd9,
      M_DBL_START      = 5'd10,
      M_DBL            = 5'd11,
      M_DBL_DASH       = 5'd12,
      M_DBL_DASH_DASH  = 5'd13,
      M_DBL_LT         = 5'd14,
      M_DBL_END        = 5'd15,
      M_EXIT_ATTR      = 5'd16,
      M_EXIT_CLOSED    = 5'd17
   } mode_type;

   typedef enum logic [1:0] {
      EV_NONE       = 2'd0,
      EV_CLOSED     = 2'd1,
      EV_ATTRS      = 2'd2,
      EV_SELF_CLOSE = 2'd3
   } event_type;

   // where the name start position comes from after a byte
   typedef enum logic [1:0] {
      NS_KEEP     = 2'd0,
      NS_POS      = 2'd1,
      NS_POS_NEXT = 2'd2
   } ns_sel_type;

   typedef struct packed {
      mode_type   next_mode;
      logic [2:0] name_length;
      logic       name_matches;
      logic       lt_hit;
      ns_sel_type ns_sel;
      event_type  end_event;
   } step_type;

   typedef struct packed {
      logic [4:0]                   scan_state;
      logic [1:0]                   end_event;
      logic [OUT_POSITION_BITS-1:0] tag_lt_position;
      logic [OUT_POSITION_BITS-1:0] name_position;
   } result_type;

   function automatic logic is_ws(input logic [7:0] b);
      return b == 8'h09 || b == 8'h0A || b == 8'h0C || b == 8'h0D || b == 8'h20;
   endfunction

   function automatic logic is_alpha(input logic [7:0] b);
      return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
   endfunction

   function automatic logic is_term(input logic [7:0] b);
      return is_ws(b) || b == CHAR_SLASH || b == CHAR_GT;
   endfunction

   // lower-case letters of "script"
   function automatic logic [7:0] want_char(input logic [2:0] idx);
      logic [7:0] c;
      unique case (idx)
         3'd0:    c = 8'h73;
         3'd1:    c = 8'h63;
         3'd2:    c = 8'h72;
         3'd3:    c = 8'h69;
         3'd4:    c = 8'h70;
         3'd5:    c = 8'h74;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

>>> hdl/sdet_step.sv
module sdet_step (
   input  logic [7:0]         data_byte,
   input  sdet_pkg::mode_type mode,
   input  logic [2:0]         name_length,
   input  logic               name_matches,
   output sdet_pkg::step_type result
);
   import sdet_pkg::*;

   always_comb begin
      mode_type   m;
      logic [2:0] len;
      logic       mat;
      logic       lt;
      ns_sel_type ns;
      event_type  ev;
      logic       done;
      logic       hit;
      logic       alpha;
      logic       term;

      m     = mode;
      len   = name_length;
      mat   = name_matches;
      lt    = 1'b0;
      ns    = NS_KEEP;
      ev    = EV_NONE;
      done  = 1'b0;
      alpha = is_alpha(data_byte);
      term  = is_term(data_byte);
      hit   = 1'b0;

      // a byte left unconsumed is looked at again in the new mode
      for (int i = 0; i < MAX_PASSES; i++) begin
         if (!done) begin
            hit = (len == 3'(NAME_LENGTH_TARGET)) && mat;
            unique case (m)
               M_PLAIN: begin
                  if (data_byte == CHAR_LT) begin
                     lt = 1'b1;
                     m  = M_LT;
                  end
                  done = 1'b1;
               end
               M_LT: begin
                  if (data_byte == CHAR_SLASH) begin
                     m    = M_END_NAME;
                     ns   = NS_POS;
                     len  = '0;
                     mat  = 1'b1;
                     done = 1'b1;
                  end else if (data_byte == CHAR_BANG) begin
                     m    = M_ESC_START;
                     done = 1'b1;
                  end else begin
                     m = M_PLAIN;
                  end
               end
               M_ESC_START: begin
                  if (data_byte == CHAR_DASH) begin
                     m    = M_ESC_START_DASH;
                     done = 1'b1;
                  end else begin
                     m = M_PLAIN;
                  end
               end
               M_ESC_START_DASH: begin
                  if (data_byte == CHAR_DASH) begin
                     m    = M_ESC_DASH_DASH;
                     done = 1'b1;
                  end else begin
                     m = M_PLAIN;
                  end
               end
               M_END_NAME, M_ESC_END_NAME: begin
                  if (alpha) begin
                     if (len == '0) ns = NS_POS;
                     if (len < 3'(NAME_LENGTH_TARGET) &&
                         (data_byte | CASE_BIT) != want_char(len)) mat = 1'b0;
                     if (len != 3'd7) len = len + 3'd1;
                     done = 1'b1;
                  end else if (term) begin
                     if (hit) begin
                        if (data_byte == CHAR_GT) begin
                           ev = EV_CLOSED;
                           m  = M_EXIT_CLOSED;
                        end else if (data_byte == CHAR_SLASH) begin
                           ev = EV_SELF_CLOSE;
                           m  = M_EXIT_ATTR;
                        end else begin
                           ev = EV_ATTRS;
                           m  = M_EXIT_ATTR;
                        end
                     end else begin
                        m = (m == M_END_NAME) ? M_PLAIN : M_ESC;
                     end
                     done = 1'b1;
                  end else begin
                     m = (m == M_END_NAME) ? M_PLAIN : M_ESC;
                  end
               end
               M_ESC: begin
                  if (data_byte == CHAR_DASH) begin
                     m = M_ESC_DASH;
                  end else if (data_byte == CHAR_LT) begin
                     lt = 1'b1;
                     m  = M_ESC_LT;
                  end
                  done = 1'b1;
               end
               M_ESC_DASH: begin
                  if (data_byte == CHAR_DASH) begin
                     m    = M_ESC_DASH_DASH;
                     done = 1'b1;
                  end else if (data_byte == CHAR_LT) begin
                     lt = 1'b1;
                     m  = M_ESC_LT;
                  end else begin
                     m    = M_ESC;
                     done = 1'b1;
                  end
               end
               M_ESC_DASH_DASH: begin
                  if (data_byte == CHAR_LT) begin
                     lt = 1'b1;
                     m  = M_ESC_LT;
                  end else if (data_byte == CHAR_GT) begin
                     m = M_PLAIN;
                  end else if (data_byte != CHAR_DASH) begin
                     m = M_ESC;
                  end
                  done = 1'b1;
               end
               M_ESC_LT: begin
                  if (data_byte == CHAR_SLASH) begin
                     m    = M_ESC_END_NAME;
                     ns   = NS_POS;
                     len  = '0;
                     mat  = 1'b1;
                     done = 1'b1;
                  end else if (alpha) begin
                     ns  = NS_POS;
                     len = '0;
                     mat = 1'b1;
                     m   = M_DBL_START;
                  end else begin
                     m = M_ESC;
                  end
               end
               M_DBL_START, M_DBL_END: begin
                  if (alpha) begin
                     if (len < 3'(NAME_LENGTH_TARGET) &&
                         (data_byte | CASE_BIT) != want_char(len)) mat = 1'b0;
                     if (len != 3'd7) len = len + 3'd1;
                     done = 1'b1;
                  end else if (term) begin
                     if (hit) m = (m == M_DBL_START) ? M_DBL : M_ESC;
                     else     m = (m == M_DBL_START) ? M_ESC : M_DBL;
                     done = 1'b1;
                  end else begin
                     m = (m == M_DBL_START) ? M_ESC : M_DBL;
                  end
               end
               M_DBL: begin
                  if (data_byte == CHAR_DASH) begin
                     m = M_DBL_DASH;
                  end else if (data_byte == CHAR_LT) begin
                     lt = 1'b1;
                     m  = M_DBL_LT;
                  end
                  done = 1'b1;
               end
               M_DBL_DASH: begin
                  if (data_byte == CHAR_DASH) begin
                     m = M_DBL_DASH_DASH;
                  end else if (data_byte == CHAR_LT) begin
                     lt = 1'b1;
                     m  = M_DBL_LT;
                  end else begin
                     m = M_DBL;
                  end
                  done = 1'b1;
               end
               M_DBL_DASH_DASH: begin
                  if (data_byte == CHAR_LT) begin
                     lt = 1'b1;
                     m  = M_DBL_LT;
                  end else if (data_byte == CHAR_GT) begin
                     m = M_PLAIN;
                  end else if (data_byte != CHAR_DASH) begin
                     m = M_DBL;
                  end
                  done = 1'b1;
               end
               M_DBL_LT: begin
                  if (data_byte == CHAR_SLASH) begin
                     m    = M_DBL_END;
                     ns   = NS_POS_NEXT;
                     len  = '0;
                     mat  = 1'b1;
                     done = 1'b1;
                  end else begin
                     m = M_DBL;
                  end
               end
               default: begin
                  // exited: byte ignored until restart
                  done = 1'b1;
               end
            endcase
         end
      end

      result.next_mode    = m;
      result.name_length  = len;
      result.name_matches = mat;
      result.lt_hit       = lt;
      result.ns_sel       = ns;
      result.end_event    = ev;
   end

endmodule

>>> hdl/script_data_end_tag_scanner_top.sv
// channel   direction  ports                                         transfer
// req       in         req_valid req_stall req_data_byte req_restart  valid && !stall
// rsp       out        rsp_valid rsp_stall rsp_scan_state
//                      rsp_end_event rsp_tag_lt_position
//                      rsp_name_position                              valid && !stall
//
// one byte per cycle while req_stall is low; each byte's result is registered
// the whole script-data step (up to eight mode passes) is one combinational
// path from the scan state registers to the result register
// a two-entry output (result register plus skid) keeps req open while rsp stalls
// req_stall rises only when both output entries are full
// reset (synchronous) clears the scan state, positions and both output entries
module script_data_end_tag_scanner_top #(
   parameter int unsigned POSITION_BITS = sdet_pkg::POSITION_BITS_DEFAULT
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        req_valid,
   output logic                                        req_stall,
   input  logic [7:0]                                  req_data_byte,
   input  logic                                        req_restart,
   output logic                                        rsp_valid,
   input  logic                                        rsp_stall,
   output logic [4:0]                                  rsp_scan_state,
   output logic [1:0]                                  rsp_end_event,
   output logic [sdet_pkg::OUT_POSITION_BITS-1:0]      rsp_tag_lt_position,
   output logic [sdet_pkg::OUT_POSITION_BITS-1:0]      rsp_name_position
);
   import sdet_pkg::*;

   localparam int unsigned EXT_BITS = POSITION_BITS + OUT_POSITION_BITS;

   mode_type                 mode_ff;
   logic [POSITION_BITS-1:0] pos_ff;
   logic [POSITION_BITS-1:0] lt_pos_ff;
   logic [POSITION_BITS-1:0] ns_pos_ff;
   logic [2:0]               name_len_ff;
   logic                     name_match_ff;

   mode_type                 mode_cur;
   step_type                 step;
   logic [POSITION_BITS-1:0] pos_next;
   logic [POSITION_BITS-1:0] lt_pos_in;
   logic [POSITION_BITS-1:0] ns_pos_in;
   logic [EXT_BITS-1:0]      lt_ext;
   logic [EXT_BITS-1:0]      ns_ext;
   result_type               result_in;

   result_type               main_ff;
   logic                     main_valid_ff;
   result_type               skid_ff;
   logic                     skid_valid_ff;

   logic                     req_take;
   logic                     rsp_take;

   assign req_stall = skid_valid_ff;
   assign req_take  = req_valid && !skid_valid_ff;
   assign rsp_take  = main_valid_ff && !rsp_stall;

   assign mode_cur = req_restart ? M_PLAIN : mode_ff;

   sdet_step u_step (
      .data_byte    (req_data_byte),
      .mode         (mode_cur),
      .name_length  (name_len_ff),
      .name_matches (name_match_ff),
      .result       (step)
   );

   assign pos_next  = pos_ff + POSITION_BITS'(1);
   assign lt_pos_in = step.lt_hit ? pos_ff : lt_pos_ff;

   always_comb begin
      unique case (step.ns_sel)
         NS_POS:      ns_pos_in = pos_ff;
         NS_POS_NEXT: ns_pos_in = pos_next;
         default:     ns_pos_in = ns_pos_ff;
      endcase
   end

   assign lt_ext = {{OUT_POSITION_BITS{1'b0}}, lt_pos_in};
   assign ns_ext = {{OUT_POSITION_BITS{1'b0}}, ns_pos_in};

   assign result_in.scan_state      = step.next_mode;
   assign result_in.end_event       = step.end_event;
   assign result_in.tag_lt_position = lt_ext[OUT_POSITION_BITS-1:0];
   assign result_in.name_position   = ns_ext[OUT_POSITION_BITS-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= M_PLAIN;
         pos_ff        <= '0;
         lt_pos_ff     <= '0;
         ns_pos_ff     <= '0;
         name_len_ff   <= '0;
         name_match_ff <= 1'b1;
      end else if (req_take) begin
         mode_ff       <= step.next_mode;
         pos_ff        <= pos_next;
         lt_pos_ff     <= lt_pos_in;
         ns_pos_ff     <= ns_pos_in;
         name_len_ff   <= step.name_length;
         name_match_ff <= step.name_matches;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_take) begin
            main_ff       <= skid_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (req_take) begin
         if (!main_valid_ff || rsp_take) begin
            main_ff       <= result_in;
            main_valid_ff <= 1'b1;
         end else begin
            skid_ff       <= result_in;
            skid_valid_ff <= 1'b1;
         end
      end else if (rsp_take) begin
         main_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid           = main_valid_ff;
   assign rsp_scan_state      = main_ff.scan_state;
   assign rsp_end_event       = main_ff.end_event;
   assign rsp_tag_lt_position = main_ff.tag_lt_position;
   assign rsp_name_position   = main_ff.name_position;

endmodule

>>> hdl/sdet_checker.sv
module sdet_checker (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   req_valid,
   input logic                                   req_stall,
   input logic [7:0]                             req_data_byte,
   input logic                                   req_restart,
   input logic                                   rsp_valid,
   input logic                                   rsp_stall,
   input logic [4:0]                             rsp_scan_state,
   input logic [1:0]                             rsp_end_event,
   input logic [sdet_pkg::OUT_POSITION_BITS-1:0] rsp_tag_lt_position,
   input logic [sdet_pkg::OUT_POSITION_BITS-1:0] rsp_name_position
);
   import sdet_pkg::*;

   // a held request keeps its byte and restart flag
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_data_byte) &&
         $stable(req_restart))
      else $error("stalled request changed");

   // a held result keeps its contents
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_scan_state) &&
         $stable(rsp_end_event) && $stable(rsp_tag_lt_position) &&
         $stable(rsp_name_position))
      else $error("stalled result changed");

   // input is only held off while a result is waiting
   a_stall_needs_rsp: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("req stalled with no result pending");

   // a closed tag always leaves the closed exit state
   a_closed_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_end_event == EV_CLOSED |-> rsp_scan_state == M_EXIT_CLOSED)
      else $error("closed event without closed exit state");

   // attribute or self-closing events leave the attribute exit state
   a_attr_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_end_event == EV_ATTRS || rsp_end_event == EV_SELF_CLOSE)
         |-> rsp_scan_state == M_EXIT_ATTR)
      else $error("attribute event without attribute exit state");

endmodule

bind script_data_end_tag_scanner_top sdet_checker u_sdet_checker (.*);
